// ===== design/sfbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Simplex fBm package
// Types, fixed-point constants and gradient tables shared by the simplex
// noise fractal-sum block and its submodules.
// ----------------------------------------------------------------------------
package sfbm_pkg;

   // Item commands.
   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_PIXEL = 1'b1
   } cmd_type;

   localparam int PERM_SIZE = 256;
   localparam int PERM_AW   = 8;

   localparam int POS_W = 32;  // octave position, Q16.16
   localparam int FX_W  = 48;  // pixel times inverse width
   localparam int AMP_W = 17;  // amplitude, Q1.16 up to one
   localparam int BX_W  = 36;  // unskewed offsets before range check
   localparam int D_W   = 18;  // in-range corner offsets
   localparam int OCT_W = 34;  // weighted octave value, Q6.28
   localparam int ACC_W = 36;  // octave accumulator

   localparam logic [15:0]      SKEW_Q16   = 16'd23988;
   localparam logic [13:0]      UNSKEW_Q16 = 14'd13849;
   localparam logic [15:0]      GAIN_Q16   = 16'd42598;
   localparam logic [AMP_W-1:0] ONE_AMP    = 17'h10000;
   localparam int               ONE_Q16    = 65536;
   localparam int               HALF_Q16   = 32768;

   // Control that travels along with each item through the octave pipeline.
   typedef struct packed {
      logic                 valid;
      logic                 load;
      logic                 first;
      logic                 last;
      logic [AMP_W-1:0]     amp;
      logic [PERM_AW-1:0]   widx;
      logic [7:0]           wval;
   } meta_type;

   // Gradient k is (cos, sin) of k*pi/4 in Q1.15.
   function automatic logic signed [15:0] grad_x_of(input logic [2:0] g);
      logic signed [15:0] v;
      unique case (g)
         3'd0: v = 16'sd32767;
         3'd1: v = 16'sd23170;
         3'd2: v = 16'sd0;
         3'd3: v = -16'sd23170;
         3'd4: v = -16'sd32767;
         3'd5: v = -16'sd23170;
         3'd6: v = 16'sd0;
         3'd7: v = 16'sd23170;
         default: v = 16'sd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [15:0] grad_y_of(input logic [2:0] g);
      logic signed [15:0] v;
      unique case (g)
         3'd0: v = 16'sd0;
         3'd1: v = 16'sd23170;
         3'd2: v = 16'sd32767;
         3'd3: v = 16'sd23170;
         3'd4: v = 16'sd0;
         3'd5: v = -16'sd23170;
         3'd6: v = -16'sd32767;
         3'd7: v = -16'sd23170;
         default: v = 16'sd0;
      endcase
      return v;
   endfunction

endpackage

// ===== design/sfbm_perm_ram.sv =====
// ----------------------------------------------------------------------------
// Permutation table memory
// 256 x 8 synchronous memory, one write port and two registered read ports.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module sfbm_perm_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [sfbm_pkg::PERM_AW-1:0]  wr_addr,
   input  logic [7:0]                    wr_data,
   input  logic [sfbm_pkg::PERM_AW-1:0]  rd_addr_a,
   input  logic [sfbm_pkg::PERM_AW-1:0]  rd_addr_b,
   output logic [7:0]                    rd_data_a,
   output logic [7:0]                    rd_data_b
);
   import sfbm_pkg::*;

   logic [7:0] mem [PERM_SIZE];
   logic [7:0] rd_a_ff;
   logic [7:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== design/sfbm_octave_core.sv =====
// ----------------------------------------------------------------------------
// Simplex octave core
// Thirteen-stage pipeline that evaluates one weighted simplex-noise octave
// per cycle. Holds three copies of the permutation table; table loads travel
// down the same pipeline so they stay in order with the lookups.
// ----------------------------------------------------------------------------
module sfbm_octave_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sfbm_pkg::meta_type                   in_meta,
   input  logic [sfbm_pkg::POS_W-1:0]           in_x,
   input  logic [sfbm_pkg::POS_W-1:0]           in_y,
   output sfbm_pkg::meta_type                   out_meta,
   output logic signed [sfbm_pkg::OCT_W-1:0]    out_value
);
   import sfbm_pkg::*;

   localparam int STAGES = 13;
   localparam logic signed [BX_W-1:0] ONE_D   = BX_W'(ONE_Q16);
   localparam logic signed [BX_W-1:0] G1_D    = BX_W'(UNSKEW_Q16);
   localparam logic signed [BX_W-1:0] G2_D    = BX_W'(2 * UNSKEW_Q16) - BX_W'(ONE_Q16);

   meta_type meta_ff [1:STAGES];

   // Skew and cell selection.
   logic [POS_W-1:0]     x1_ff, y1_ff, x2_ff, y2_ff, x3_ff, y3_ff, x4_ff, y4_ff;
   logic [POS_W:0]       sum1_ff;
   logic [POS_W-1:0]     s2_ff;
   logic [16:0]          cbx3_ff, cby3_ff, cbx4_ff, cby4_ff;
   logic [31:0]          un4_ff;
   logic signed [BX_W-1:0] bx5_ff, by5_ff;

   logic [48:0]          skew_prod;
   logic [POS_W:0]       xs, ys;
   logic [31:0]          un_prod;

   // Corner arithmetic, one lane per corner.
   logic signed [D_W-1:0]  dx6_ff [3];
   logic signed [D_W-1:0]  dy6_ff [3];
   logic                   ok6_ff [3];
   logic [2:0]             g6_ff  [3];
   logic [15:0]            sqx7_ff [3];
   logic [15:0]            sqy7_ff [3];
   logic signed [33:0]     pgx7_ff [3];
   logic signed [33:0]     pgy7_ff [3];
   logic                   ok7_ff  [3];
   logic [15:0]            t8_ff   [3];
   logic signed [34:0]     dot8_ff [3];
   logic [14:0]            t9_ff   [3];
   logic signed [34:0]     dot9_ff [3];
   logic [12:0]            t10_ff  [3];
   logic signed [34:0]     dot10_ff [3];
   logic signed [48:0]     prod11_ff [3];
   logic signed [31:0]     sum12_ff;
   logic signed [OCT_W-1:0] oct13_ff;

   logic signed [BX_W-1:0] dx_full [3];
   logic signed [BX_W-1:0] dy_full [3];
   logic                   mi;
   logic [2:0]             g_sel [3];

   // Table copies: inner lookup, and two for the outer lookups.
   logic                 wr_en;
   logic [7:0]           inner_a, inner_b, outer_b_a, outer_b_b, outer_c_a, outer_c_b;
   logic [PERM_AW-1:0]   cx8;

   assign wr_en = meta_ff[3].valid && meta_ff[3].load;
   assign cx8   = cbx4_ff[PERM_AW-1:0];

   sfbm_perm_ram u_ram_inner (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (meta_ff[3].widx),
      .wr_data   (meta_ff[3].wval),
      .rd_addr_a (cby3_ff[PERM_AW-1:0]),
      .rd_addr_b (cby3_ff[PERM_AW-1:0] + PERM_AW'(1)),
      .rd_data_a (inner_a),
      .rd_data_b (inner_b)
   );

   sfbm_perm_ram u_ram_outer_b (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (meta_ff[3].widx),
      .wr_data   (meta_ff[3].wval),
      .rd_addr_a (cx8 + inner_a),
      .rd_addr_b (cx8 + inner_a + PERM_AW'(1)),
      .rd_data_a (outer_b_a),
      .rd_data_b (outer_b_b)
   );

   sfbm_perm_ram u_ram_outer_c (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (meta_ff[3].widx),
      .wr_data   (meta_ff[3].wval),
      .rd_addr_a (cx8 + inner_b),
      .rd_addr_b (cx8 + inner_b + PERM_AW'(1)),
      .rd_data_a (outer_c_a),
      .rd_data_b (outer_c_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= STAGES; i++) begin
            meta_ff[i] <= '0;
         end
      end else begin
         meta_ff[1] <= in_meta;
         for (int i = 2; i <= STAGES; i++) begin
            meta_ff[i] <= meta_ff[i-1];
         end
      end
   end

   always_comb begin
      skew_prod = {16'b0, sum1_ff} * {33'b0, SKEW_Q16};
      xs        = {1'b0, x2_ff} + {1'b0, s2_ff};
      ys        = {1'b0, y2_ff} + {1'b0, s2_ff};
      un_prod   = ({15'b0, cbx3_ff} + {15'b0, cby3_ff}) * {18'b0, UNSKEW_Q16};
   end

   // Stages one to five: skew, cell origin, unskewed offset of the base corner.
   always_ff @(posedge clock) begin
      x1_ff   <= in_x;
      y1_ff   <= in_y;
      sum1_ff <= {1'b0, in_x} + {1'b0, in_y};
      x2_ff   <= x1_ff;
      y2_ff   <= y1_ff;
      s2_ff   <= skew_prod[47:16];
      x3_ff   <= x2_ff;
      y3_ff   <= y2_ff;
      cbx3_ff <= xs[POS_W:16];
      cby3_ff <= ys[POS_W:16];
      x4_ff   <= x3_ff;
      y4_ff   <= y3_ff;
      cbx4_ff <= cbx3_ff;
      cby4_ff <= cby3_ff;
      un4_ff  <= un_prod;
      bx5_ff  <= $signed({4'b0, x4_ff}) - $signed({3'b0, cbx4_ff, 16'b0})
                 + $signed({4'b0, un4_ff});
      by5_ff  <= $signed({4'b0, y4_ff}) - $signed({3'b0, cby4_ff, 16'b0})
                 + $signed({4'b0, un4_ff});
   end

   // Stage six: pick the middle corner and gather the three offsets.
   always_comb begin
      mi         = bx5_ff > by5_ff;
      dx_full[0] = bx5_ff;
      dy_full[0] = by5_ff;
      dx_full[1] = bx5_ff - (mi ? ONE_D : '0) + G1_D;
      dy_full[1] = by5_ff - (mi ? '0 : ONE_D) + G1_D;
      dx_full[2] = bx5_ff + G2_D;
      dy_full[2] = by5_ff + G2_D;
      g_sel[0]   = outer_b_a[2:0];
      g_sel[1]   = mi ? outer_b_b[2:0] : outer_c_a[2:0];
      g_sel[2]   = outer_c_b[2:0];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         dx6_ff[i] <= dx_full[i][D_W-1:0];
         dy6_ff[i] <= dy_full[i][D_W-1:0];
         ok6_ff[i] <= (dx_full[i] < ONE_D) && (dx_full[i] > -ONE_D)
                      && (dy_full[i] < ONE_D) && (dy_full[i] > -ONE_D);
         g6_ff[i]  <= g_sel[i];
      end
   end

   // Stages seven to eleven: attenuation to the fourth power and gradient dot.
   logic signed [35:0] sqx_full [3];
   logic signed [35:0] sqy_full [3];
   logic signed [17:0] t_full   [3];
   logic [31:0]        tsq      [3];
   logic [29:0]        t2sq     [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sqx_full[i] = dx6_ff[i] * dx6_ff[i];
         sqy_full[i] = dy6_ff[i] * dy6_ff[i];
         t_full[i]   = 18'(HALF_Q16) - $signed({2'b0, sqx7_ff[i]})
                       - $signed({2'b0, sqy7_ff[i]});
         tsq[i]      = t8_ff[i] * t8_ff[i];
         t2sq[i]     = t9_ff[i] * t9_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sqx7_ff[i]   <= sqx_full[i][31:16];
         sqy7_ff[i]   <= sqy_full[i][31:16];
         pgx7_ff[i]   <= grad_x_of(g6_ff[i]) * dx6_ff[i];
         pgy7_ff[i]   <= grad_y_of(g6_ff[i]) * dy6_ff[i];
         ok7_ff[i]    <= ok6_ff[i];
         // An out-of-range corner or a negative attenuation adds nothing.
         t8_ff[i]     <= (ok7_ff[i] && !t_full[i][17]) ? t_full[i][15:0] : 16'd0;
         dot8_ff[i]   <= {pgx7_ff[i][33], pgx7_ff[i]} + {pgy7_ff[i][33], pgy7_ff[i]};
         t9_ff[i]     <= tsq[i][30:16];
         dot9_ff[i]   <= dot8_ff[i];
         t10_ff[i]    <= t2sq[i][28:16];
         dot10_ff[i]  <= dot9_ff[i];
         prod11_ff[i] <= $signed({1'b0, t10_ff[i]}) * dot10_ff[i];
      end
   end

   // Stages twelve and thirteen: corner sum, then octave amplitude.
   logic signed [29:0] corner [3];
   logic signed [49:0] oct_full;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         corner[i] = prod11_ff[i][48:19];
      end
      oct_full = sum12_ff * $signed({1'b0, meta_ff[12].amp});
   end

   always_ff @(posedge clock) begin
      sum12_ff <= 32'(corner[0]) + 32'(corner[1]) + 32'(corner[2]);
      oct13_ff <= oct_full[49:16];
   end

   assign out_meta  = meta_ff[STAGES];
   assign out_value = oct13_ff;

endmodule

// ===== design/simplex_noise_fbm_2d.sv =====
// ----------------------------------------------------------------------------
// Simplex noise fractal sum, 2D
// Returns the fixed-point fBm altitude of a pixel from OCTAVES octaves of
// two-dimensional simplex noise over a loadable permutation table.
// ----------------------------------------------------------------------------
// Usage.
// An item is taken at a rising edge with start high and busy low. With
// req_command set to load, the item writes req_table_value into permutation
// entry req_table_index and gives no result. With req_command set to pixel,
// the item computes the altitude of (req_pixel_x, req_pixel_y).
// The first-octave frequency is written through csr_valid/csr_wdata, which is
// always ready; write it only while no pixel is in flight.
// The issue stage sends one octave per cycle, so a pixel holds busy while
// its remaining octaves issue and the next item is accepted in the cycle
// its last octave issues; loads are taken one per cycle. Each pixel passes
// the issue stage, the thirteen-stage octave pipeline and the result
// register; rsp_valid then pulses for one cycle, with rsp_altitude holding
// the saturated Q4.28 sum. The receiver cannot stall; results are presented
// once, in order. Reset empties the pipeline, drops any pixel in flight and
// restores the default frequency of 1/256; the permutation table is not
// cleared and must be loaded before pixels are sent.
// ----------------------------------------------------------------------------
module simplex_noise_fbm_2d #(
   parameter int OCTAVES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [15:0] req_pixel_x,
   input  logic [15:0] req_pixel_y,
   input  logic [7:0]  req_table_index,
   input  logic [7:0]  req_table_value,
   output logic        rsp_valid,
   output logic signed [31:0] rsp_altitude,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata
);
   import sfbm_pkg::*;

   localparam int CNT_W = (OCTAVES > 1) ? $clog2(OCTAVES) : 1;
   localparam logic [31:0] INV_WIDTH_RESET = 32'd16777216;
   localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sd2147483648);

   // Configuration register.
   logic [31:0] inv_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_width_ff <= INV_WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         inv_width_ff <= csr_wdata;
      end
   end

   assign csr_ready = 1'b1;

   // Issue stage: holds the current item and steps through its octaves. The
   // octave position is the pixel-times-frequency product doubled each step;
   // only the low 48 bits matter because the position keeps 32 bits above
   // the binary point's lower 16.
   logic               active_ff, load_ff, first_ff;
   logic [CNT_W-1:0]   left_ff;
   logic [FX_W-1:0]    fx_ff, fy_ff;
   logic [AMP_W-1:0]   amp_ff;
   logic [7:0]         widx_ff, wval_ff;
   logic               accept;
   logic [32:0]        amp_prod;
   logic [FX_W-1:0]    fx_prod, fy_prod;

   assign busy     = active_ff && (left_ff != '0);
   assign accept   = start && !busy;
   assign amp_prod = {16'b0, amp_ff} * {17'b0, GAIN_Q16};
   assign fx_prod  = {32'b0, req_pixel_x} * {16'b0, inv_width_ff};
   assign fy_prod  = {32'b0, req_pixel_y} * {16'b0, inv_width_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         load_ff   <= 1'b0;
         first_ff  <= 1'b0;
         left_ff   <= '0;
      end else if (accept) begin
         active_ff <= 1'b1;
         load_ff   <= (req_command == CMD_LOAD);
         first_ff  <= 1'b1;
         left_ff   <= (req_command == CMD_PIXEL) ? CNT_W'(OCTAVES - 1) : '0;
      end else if (active_ff) begin
         if (left_ff == '0) begin
            active_ff <= 1'b0;
         end else begin
            left_ff  <= left_ff - CNT_W'(1);
            first_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fx_ff   <= fx_prod;
         fy_ff   <= fy_prod;
         amp_ff  <= ONE_AMP;
         widx_ff <= req_table_index;
         wval_ff <= req_table_value;
      end else if (active_ff) begin
         fx_ff  <= {fx_ff[FX_W-2:0], 1'b0};
         fy_ff  <= {fy_ff[FX_W-2:0], 1'b0};
         amp_ff <= amp_prod[32:16];
      end
   end

   meta_type            issue_meta, core_meta;
   logic signed [OCT_W-1:0] core_value;

   always_comb begin
      issue_meta.valid = active_ff;
      issue_meta.load  = load_ff;
      issue_meta.first = first_ff;
      issue_meta.last  = (left_ff == '0);
      issue_meta.amp   = amp_ff;
      issue_meta.widx  = widx_ff;
      issue_meta.wval  = wval_ff;
   end

   sfbm_octave_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_meta   (issue_meta),
      .in_x      (fx_ff[FX_W-1:16]),
      .in_y      (fy_ff[FX_W-1:16]),
      .out_meta  (core_meta),
      .out_value (core_value)
   );

   // Octave accumulator and result register. Octaves of one pixel arrive
   // back to back; the first one restarts the sum.
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    rsp_valid_ff;
   logic signed [31:0]      rsp_alt_ff, sat_value;
   logic                    octave_done;

   assign octave_done = core_meta.valid && !core_meta.load;

   always_comb begin
      acc_in = (core_meta.first ? '0 : acc_ff) + ACC_W'(core_value);
      priority if (acc_in > SAT_MAX) begin
         sat_value = 32'sh7FFFFFFF;
      end else if (acc_in < SAT_MIN) begin
         sat_value = 32'sh80000000;
      end else begin
         sat_value = acc_in[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= octave_done && core_meta.last;
      end
   end

   always_ff @(posedge clock) begin
      if (octave_done) begin
         acc_ff <= acc_in;
      end
      if (octave_done && core_meta.last) begin
         rsp_alt_ff <= sat_value;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_altitude = rsp_alt_ff;

endmodule

// ===== design/sfbm_checker.sv =====
// ----------------------------------------------------------------------------
// Simplex fBm port checker
// Checks issue timing, fixed result latency and reset behavior seen on the
// ports of the simplex fBm block.
// ----------------------------------------------------------------------------
module sfbm_checker #(
   parameter int OCTAVES = 16
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_command,
   input logic rsp_valid
);
   import sfbm_pkg::*;

   localparam int LATENCY = OCTAVES + 14;

   logic pixel_taken;
   assign pixel_taken = start && !busy && (req_command == CMD_PIXEL);

   // A pixel holds the block busy while its remaining octaves issue.
   assert property (@(posedge clock) disable iff (reset)
      pixel_taken |=> (busy || (OCTAVES == 1)))
      else $error("busy not raised after a pixel item");

   // Every pixel gives its result after the fixed pipeline latency.
   assert property (@(posedge clock) disable iff (reset)
      pixel_taken |-> ##LATENCY rsp_valid)
      else $error("pixel result missing at expected latency");

   // No result appears without a matching pixel taken before it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(pixel_taken, LATENCY))
      else $error("result without a matching pixel item");

   // Reset leaves the block idle with no result pending.
   assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("block not idle after reset");

endmodule

bind simplex_noise_fbm_2d sfbm_checker #(.OCTAVES(OCTAVES)) u_sfbm_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_command (req_command),
   .rsp_valid   (rsp_valid)
);

// ===== bench/tb_simplex_noise_fbm_2d.sv =====
// ----------------------------------------------------------------------------
// Simplex fBm block testbench
// Fills the permutation table, then sends pixel and load items under several
// first-octave frequencies and checks every altitude against a fixed-point
// model of the octave sum kept inside a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_simplex_noise_fbm_2d;
   import sfbm_pkg::*;

   // Generous bound: every pixel costs its octaves plus gaps and the pipeline
   // drain, so CYCLE_LIMIT is far beyond need.
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 40;
   localparam int RAND_ITEMS  = 155;

   // The altitude store: it mirrors the permutation table and the frequency
   // register, predicts the altitude of each pixel item and compares it with
   // what the block returns, oldest first.
   class altitude_board;
      logic [7:0]         perm [PERM_SIZE];
      logic [31:0]        inv_width;
      logic signed [31:0] pending_alt [$];
      int                 failures;

      function new();
         inv_width = 32'd16777216;
         failures  = 0;
         foreach (perm[i]) perm[i] = 8'd0;
      endfunction

      function longint grad_x(int g);
         case (g)
            0: return 32767;
            1: return 23170;
            3: return -23170;
            4: return -32767;
            5: return -23170;
            7: return 23170;
            default: return 0;
         endcase
      endfunction

      function longint grad_y(int g);
         case (g)
            1: return 23170;
            2: return 32767;
            3: return 23170;
            5: return -23170;
            6: return -32767;
            7: return -23170;
            default: return 0;
         endcase
      endfunction

      // One corner: (0.5 - d.d)^4 * (g . d), dropped when out of reach.
      function longint corner(longint dx, longint dy, int g);
         longint t, t2, t4, dot;
         if (dx >= ONE_Q16 || dx <= -ONE_Q16 || dy >= ONE_Q16 || dy <= -ONE_Q16)
            return 0;
         t = HALF_Q16 - ((dx * dx) >>> 16) - ((dy * dy) >>> 16);
         if (t < 0)
            return 0;
         t2  = (t * t) >>> 16;
         t4  = (t2 * t2) >>> 16;
         dot = grad_x(g) * dx + grad_y(g) * dy;
         return (t4 * dot) >>> 19;
      endfunction

      function int gradient_of(longint cx, longint cy);
         logic [7:0] inner;
         inner = perm[cy & 255];
         return perm[(cx + inner) & 255] & 7;
      endfunction

      function longint noise_at(longint x, longint y);
         longint s, cbx, cby, un, bx, by, mi, mx, my, tx, ty, sum;
         s   = ((x + y) * longint'(SKEW_Q16)) >>> 16;
         cbx = (x + s) >>> 16;
         cby = (y + s) >>> 16;
         un  = (cbx + cby) * longint'(UNSKEW_Q16);
         bx  = x - cbx * ONE_Q16 + un;
         by  = y - cby * ONE_Q16 + un;
         mi  = (bx > by) ? 1 : 0;
         mx  = bx - mi * ONE_Q16 + longint'(UNSKEW_Q16);
         my  = by - (1 - mi) * ONE_Q16 + longint'(UNSKEW_Q16);
         tx  = bx - ONE_Q16 + 2 * longint'(UNSKEW_Q16);
         ty  = by - ONE_Q16 + 2 * longint'(UNSKEW_Q16);
         sum = corner(bx, by, gradient_of(cbx, cby));
         sum += corner(mx, my, gradient_of(cbx + mi, cby + 1 - mi));
         sum += corner(tx, ty, gradient_of(cbx + 1, cby + 1));
         return sum;
      endfunction

      function logic signed [31:0] altitude_of(logic [15:0] px, logic [15:0] py);
         longint fx, fy, x, y, acc, amp;
         fx  = longint'(px) * longint'(inv_width);
         fy  = longint'(py) * longint'(inv_width);
         acc = 0;
         amp = ONE_Q16;
         for (int k = 0; k < 16; k++) begin
            // Positions keep their low 32 bits, so the integer part wraps.
            x   = (fx >> (16 - k)) & 64'hFFFF_FFFF;
            y   = (fy >> (16 - k)) & 64'hFFFF_FFFF;
            acc += (noise_at(x, y) * amp) >>> 16;
            amp = (amp * longint'(GAIN_Q16)) >>> 16;
         end
         if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
         if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
         return acc[31:0];
      endfunction

      // Note an item the block has taken.
      function void note_item(cmd_type cmd, logic [15:0] px, logic [15:0] py,
                              logic [7:0] idx, logic [7:0] val);
         if (cmd == CMD_LOAD)
            perm[idx] = val;
         else
            pending_alt.push_back(altitude_of(px, py));
      endfunction

      function void check_result(logic signed [31:0] actual);
         logic signed [31:0] expected;
         if (pending_alt.size() == 0) begin
            $error("altitude: expected none, actual %0d", actual);
            failures++;
            return;
         end
         expected = pending_alt.pop_front();
         if (actual !== expected) begin
            $error("altitude: expected %0d, actual %0d", expected, actual);
            failures++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_command = 1'b0;
   logic [15:0] req_pixel_x = '0;
   logic [15:0] req_pixel_y = '0;
   logic [7:0]  req_table_index = '0;
   logic [7:0]  req_table_value = '0;
   logic        rsp_valid;
   logic signed [31:0] rsp_altitude;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_wdata = '0;

   altitude_board board = new();
   bit            gaps_on = 1'b1;
   int            cycles = 0;

   simplex_noise_fbm_2d dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_pixel_x(req_pixel_x),
      .req_pixel_y(req_pixel_y), .req_table_index(req_table_index),
      .req_table_value(req_table_value), .rsp_valid(rsp_valid),
      .rsp_altitude(rsp_altitude), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Every result strobe is checked at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_result(rsp_altitude);
   end

   // Watchdog in case a handshake never completes.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Present one item and hold it until the block takes it. Start is left
   // high so that back-to-back items need no bubble; inputs change only at
   // the falling edge, and busy is sampled at the rising edge.
   task automatic send_item(cmd_type cmd, logic [15:0] px, logic [15:0] py,
                            logic [7:0] idx, logic [7:0] val);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            @(negedge clock);
            start = 1'b0;
         end
      end
      @(negedge clock);
      start           = 1'b1;
      req_command     = cmd;
      req_pixel_x     = px;
      req_pixel_y     = py;
      req_table_index = idx;
      req_table_value = val;
      do @(posedge clock); while (busy);
      board.note_item(cmd, px, py, idx, val);
   endtask

   task automatic go_idle();
      @(negedge clock);
      start = 1'b0;
   endtask

   // Wait for every expected altitude, then for the pipeline to drain, since
   // trailing load items leave nothing behind to wait on.
   task automatic drain();
      go_idle();
      while (board.pending_alt.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_width(logic [31:0] value);
      drain();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      board.inv_width = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Mostly pixels with full-range coordinates, now and then a corner of the
   // coordinate space, and some table reloads mixed in.
   task automatic random_items(int count, bit pause_midway);
      logic [15:0] px, py;
      for (int n = 0; n < count; n++) begin
         if (pause_midway && n == count / 2)
            drain();
         if ($urandom_range(0, 3) == 0) begin
            send_item(CMD_LOAD, 16'($urandom), 16'($urandom),
                      8'($urandom), 8'($urandom));
         end else begin
            px = 16'($urandom);
            py = 16'($urandom);
            if ($urandom_range(0, 9) == 0) px = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
            if ($urandom_range(0, 9) == 0) py = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
            send_item(CMD_PIXEL, px, py, 8'($urandom), 8'($urandom));
         end
      end
   endtask

   initial begin
      logic [31:0] widths [6];
      widths = '{32'h0, 32'hFFFF_FFFF, 32'h0100_0000, 32'($urandom),
                 32'h0001_0000, 32'($urandom)};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // The table must be complete before the first pixel reads it.
      for (int i = 0; i < PERM_SIZE; i++)
         send_item(CMD_LOAD, 16'($urandom), 16'($urandom), 8'(i), 8'($urandom));

      // Directed part: coordinate extremes at the reset frequency, table
      // entries at both ends, and a pixel whose octave positions wrap.
      send_item(CMD_LOAD, 16'hFFFF, 16'hFFFF, 8'd0, 8'd255);
      send_item(CMD_LOAD, 16'h0, 16'h0, 8'd255, 8'd0);
      send_item(CMD_PIXEL, 16'h0, 16'h0, 8'hFF, 8'hFF);
      send_item(CMD_PIXEL, 16'hFFFF, 16'hFFFF, 8'h0, 8'h0);
      send_item(CMD_PIXEL, 16'h0, 16'hFFFF, 8'h0, 8'h0);
      send_item(CMD_PIXEL, 16'hFFFF, 16'h0, 8'h0, 8'h0);
      send_item(CMD_PIXEL, 16'd255, 16'd1, 8'h0, 8'h0);
      send_item(CMD_PIXEL, 16'h8000, 16'h7FFF, 8'h0, 8'h0);
      send_item(CMD_PIXEL, 16'hAAAA, 16'h5555, 8'h0, 8'h0);
      random_items(RAND_ITEMS, 1'b1);

      // Each frequency gets its own phase; the last runs without gaps.
      foreach (widths[p]) begin
         write_width(widths[p]);
         gaps_on = (p != 5);
         random_items(RAND_ITEMS, 1'b0);
      end

      drain();
      if (board.failures == 0 && board.pending_alt.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
